// ===== rtl/urlap_pkg.sv =====
// shared types, codes and constants of the url authority parser
package urlap_pkg;

    // parse modes
    localparam logic [2:0] MODE_SCHEME = 3'd0;
    localparam logic [2:0] MODE_SEP1   = 3'd1;
    localparam logic [2:0] MODE_SEP2   = 3'd2;
    localparam logic [2:0] MODE_HOST   = 3'd3;
    localparam logic [2:0] MODE_PORT   = 3'd4;
    localparam logic [2:0] MODE_PATH   = 3'd5;

    // status codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_COLON   = 3'd1;
    localparam logic [2:0] ERR_HTTPS      = 3'd2;
    localparam logic [2:0] ERR_SEPARATOR  = 3'd3;
    localparam logic [2:0] ERR_EMPTY_HOST = 3'd4;
    localparam logic [2:0] ERR_PORT_CHAR  = 3'd5;
    localparam logic [2:0] ERR_PORT_LONG  = 3'd6;
    localparam logic [2:0] ERR_PORT_EMPTY = 3'd7;

    // character roles
    localparam logic [2:0] ROLE_SCHEME    = 3'd0;
    localparam logic [2:0] ROLE_SEPARATOR = 3'd1;
    localparam logic [2:0] ROLE_HOST      = 3'd2;
    localparam logic [2:0] ROLE_PORT      = 3'd3;
    localparam logic [2:0] ROLE_PATH      = 3'd4;
    localparam logic [2:0] ROLE_ERROR     = 3'd5;

    // characters of interest
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0]  SCHEME_LEN   = 3'd5;
    localparam logic [2:0]  SEG_MAX      = 3'd7;
    localparam logic [15:0] DEFAULT_PORT = 16'd80;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  char_role;
        logic        host_copy;
        logic        done_res;
        logic [2:0]  status;
        logic [16:0] port_value;
        logic        path_given;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  match_idx;
        logic        mismatch;
        logic [2:0]  seg_len;
        logic [16:0] port_acc;
        logic        port_seen;
        logic [2:0]  error_code;
        logic        path_seen;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        mode:       MODE_SCHEME,
        match_idx:  3'd0,
        mismatch:   1'b0,
        seg_len:    3'd0,
        port_acc:   17'd0,
        port_seen:  1'b0,
        error_code: ERR_NONE,
        path_seen:  1'b0
    };

    // the rejected scheme, one letter per position
    function automatic logic [7:0] https_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h68; // h
            3'd1:    ch = 8'h74; // t
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h70; // p
            3'd4:    ch = 8'h73; // s
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/url_authority_parser.sv =====
// top level of the url authority parser: handshake, registers and parse state
// an accepted character passes the input register, then the result register, on its way to the output
// throughput: one character per cycle while out_stall lets results drain, set by the
// combinational parse step between the input register and the result register
// reset: rst_n clears the parse state, both stage valids and sets the
// default port to 80; a url in flight is dropped
module url_authority_parser
    import urlap_pkg::*;
#(
    parameter int MAX_PORT_DIGITS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    // character channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    // default port register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // input register: holds one character until the parse step can take it
    in_item_t     item_reg;
    logic         item_vld_reg;

    // result register: one finished result item
    out_item_t    res_reg;
    logic         res_vld_reg;

    // running parse state of the current url
    parse_state_t state_reg;
    parse_state_t state_next;
    out_item_t    res_next;

    logic [15:0]  default_port_reg;

    logic         advance;
    logic         in_take;

    // the parse step fires when a character waits and the result slot frees up
    assign advance  = item_vld_reg && (!res_vld_reg || !out_stall);
    // the input register refills in the same cycle it drains
    assign in_stall = item_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = res_vld_reg;
    assign out_item  = res_reg;

    urlap_step #(
        .MAX_PORT_DIGITS (MAX_PORT_DIGITS)
    ) u_step (
        .state        (state_reg),
        .item         (item_reg),
        .default_port (default_port_reg),
        .state_next   (state_next),
        .result       (res_next)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_port_reg <= DEFAULT_PORT;
        end
        else if (cfg_wr_en)
        begin
            default_port_reg <= cfg_wr_data;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            item_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
    end

    // parse state, updated once per character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // errors stay put until the url ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !item_reg.last_char && state_reg.error_code != ERR_NONE)
        |=> (state_reg.error_code == $past(state_reg.error_code)))
        else $error("sticky error changed within a url");

    // the end of a url clears the parse state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.last_char) |=> (state_reg == PARSE_CLEAR))
        else $error("parse state not cleared after last character");

    // a failed url reports neither port nor path
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.status != ERR_NONE)
        |-> (res_reg.port_value == 17'd0 && !res_reg.path_given))
        else $error("port or path reported with an error status");

    // port and path appear only on the last result of a url
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res_reg.done_res)
        |-> (res_reg.port_value == 17'd0 && !res_reg.path_given))
        else $error("port or path reported before the last character");

    // a character that failed to advance remains in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && !advance) |=> item_vld_reg)
        else $error("waiting character lost");

endmodule

// ===== rtl/urlap_step.sv =====
// per-character parse step: next parse state and the result item
module urlap_step
    import urlap_pkg::*;
#(
    parameter int MAX_PORT_DIGITS = 5
)
(
    input  parse_state_t state,
    input  in_item_t     item,
    input  logic [15:0]  default_port,
    output parse_state_t state_next,
    output out_item_t    result
);

    localparam logic [2:0] MAX_DIGITS = 3'(MAX_PORT_DIGITS);

    parse_state_t st;
    logic [2:0]   role;
    logic         hc;
    logic         is_colon;
    logic         is_slash;
    logic         is_digit;
    logic [16:0]  acc_x10;
    logic [16:0]  digit;

    assign is_colon = (item.character == CHAR_COLON);
    assign is_slash = (item.character == CHAR_SLASH);
    assign is_digit = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
    assign acc_x10  = (state.port_acc << 3) + (state.port_acc << 1);
    assign digit    = {13'd0, item.character[3:0]};

    always_comb
    begin
        st     = state;
        role   = ROLE_ERROR;
        hc     = 1'b0;
        result = '0;

        if (state.error_code == ERR_NONE)
        begin
            case (state.mode)
                MODE_SCHEME:
                begin
                    if (is_colon)
                    begin
                        if (!state.mismatch && state.match_idx == SCHEME_LEN)
                        begin
                            st.error_code = ERR_HTTPS;
                        end
                        else
                        begin
                            role    = ROLE_SEPARATOR;
                            st.mode = MODE_SEP1;
                        end
                    end
                    else
                    begin
                        role = ROLE_SCHEME;
                        if (state.match_idx >= SCHEME_LEN ||
                            item.character != https_char(state.match_idx))
                        begin
                            st.mismatch = 1'b1;
                        end
                        if (state.match_idx < SCHEME_LEN)
                        begin
                            st.match_idx = state.match_idx + 3'd1;
                        end
                    end
                end
                MODE_SEP1, MODE_SEP2:
                begin
                    if (is_slash)
                    begin
                        role = ROLE_SEPARATOR;
                        if (state.mode == MODE_SEP1)
                        begin
                            st.mode = MODE_SEP2;
                        end
                        else
                        begin
                            st.mode    = MODE_HOST;
                            st.seg_len = 3'd0;
                        end
                    end
                    else
                    begin
                        st.error_code = ERR_SEPARATOR;
                    end
                end
                MODE_HOST:
                begin
                    if (is_colon || is_slash)
                    begin
                        if (state.seg_len == 3'd0)
                        begin
                            st.error_code = ERR_EMPTY_HOST;
                        end
                        else if (is_colon)
                        begin
                            role        = ROLE_SEPARATOR;
                            hc          = 1'b1;
                            st.mode     = MODE_PORT;
                            st.seg_len  = 3'd0;
                            st.port_acc = 17'd0;
                        end
                        else
                        begin
                            role         = ROLE_PATH;
                            st.path_seen = 1'b1;
                            st.mode      = MODE_PATH;
                        end
                    end
                    else
                    begin
                        role = ROLE_HOST;
                        hc   = 1'b1;
                        if (state.seg_len < SEG_MAX)
                        begin
                            st.seg_len = state.seg_len + 3'd1;
                        end
                    end
                end
                MODE_PORT:
                begin
                    if (is_slash)
                    begin
                        if (state.seg_len > MAX_DIGITS)
                        begin
                            st.error_code = ERR_PORT_LONG;
                        end
                        else if (state.seg_len == 3'd0)
                        begin
                            st.error_code = ERR_PORT_EMPTY;
                        end
                        else
                        begin
                            role         = ROLE_PATH;
                            st.port_seen = 1'b1;
                            st.path_seen = 1'b1;
                            st.mode      = MODE_PATH;
                        end
                    end
                    else if (is_digit)
                    begin
                        role = ROLE_PORT;
                        hc   = 1'b1;
                        if (state.seg_len < MAX_DIGITS)
                        begin
                            st.port_acc = acc_x10 + digit;
                        end
                        if (state.seg_len < SEG_MAX)
                        begin
                            st.seg_len = state.seg_len + 3'd1;
                        end
                    end
                    else
                    begin
                        st.error_code = ERR_PORT_CHAR;
                    end
                end
                default:
                begin
                    role = ROLE_PATH;
                end
            endcase
        end

        result.char_role = role;
        result.host_copy = hc;
        result.done_res  = item.last_char;

        if (!item.last_char)
        begin
            result.status = st.error_code;
        end
        else
        begin
            // checks that only the end of the url can settle
            if (st.error_code == ERR_NONE)
            begin
                case (st.mode)
                    MODE_SCHEME:
                    begin
                        st.error_code = ERR_NO_COLON;
                    end
                    MODE_SEP1, MODE_SEP2:
                    begin
                        st.error_code = ERR_SEPARATOR;
                    end
                    MODE_HOST:
                    begin
                        if (st.seg_len == 3'd0)
                        begin
                            st.error_code = ERR_EMPTY_HOST;
                        end
                    end
                    MODE_PORT:
                    begin
                        if (st.seg_len == 3'd0)
                        begin
                            st.error_code = ERR_PORT_EMPTY;
                        end
                        else if (st.seg_len > MAX_DIGITS)
                        begin
                            st.error_code = ERR_PORT_LONG;
                        end
                        else
                        begin
                            st.port_seen = 1'b1;
                        end
                    end
                    default:
                    begin
                        st.error_code = st.error_code;
                    end
                endcase
            end

            result.status = st.error_code;
            if (st.error_code == ERR_NONE)
            begin
                result.port_value = st.port_seen ? st.port_acc : {1'b0, default_port};
                result.path_given = st.path_seen;
            end
        end
    end

    // a finished url leaves the parser ready for the next one
    assign state_next = item.last_char ? PARSE_CLEAR : st;

endmodule

// ===== verif/url_authority_parser_tb.sv =====
// self-checking testbench of the url authority parser: directed table, random urls, stalls
`timescale 1ns / 100ps

module url_authority_parser_tb
    import urlap_pkg::*;
();

    localparam int PORT_DIGITS   = 5;
    localparam int RANDOM_ITEMS  = 900;
    // a result item passes the input and result registers after its character; let them
    // settle before a register write
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int CFG_SPACING   = 150;

    // one directed row: the character, the end flag and, where obvious, the result
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        out_item_t  want;
    } stim_row_t;

    localparam out_item_t NO_TAG = '0;

    localparam stim_row_t DIRECTED [24] = '{
        // lone byte with no colon, still a scheme byte, fails at the end
        '{8'h01, 1'b1, 1'b1, '{ROLE_SCHEME, 1'b0, 1'b1, ERR_NO_COLON, 17'd0, 1'b0}},
        // colon then something other than a slash
        '{CHAR_COLON, 1'b0, 1'b0, NO_TAG},
        '{"x", 1'b1, 1'b1, '{ROLE_ERROR, 1'b0, 1'b1, ERR_SEPARATOR, 17'd0, 1'b0}},
        // colon right after the separator means the host is empty
        '{CHAR_COLON, 1'b0, 1'b0, NO_TAG},
        '{CHAR_SLASH, 1'b0, 1'b0, NO_TAG},
        '{CHAR_SLASH, 1'b0, 1'b0, NO_TAG},
        '{CHAR_COLON, 1'b1, 1'b1, '{ROLE_ERROR, 1'b0, 1'b1, ERR_EMPTY_HOST, 17'd0, 1'b0}},
        // top byte as host, one port digit, then a letter in the port
        '{CHAR_COLON, 1'b0, 1'b0, NO_TAG},
        '{CHAR_SLASH, 1'b0, 1'b0, NO_TAG},
        '{CHAR_SLASH, 1'b0, 1'b0, NO_TAG},
        '{8'hFF, 1'b0, 1'b0, NO_TAG},
        '{CHAR_COLON, 1'b0, 1'b0, NO_TAG},
        '{"9", 1'b0, 1'b0, NO_TAG},
        '{"x", 1'b1, 1'b1, '{ROLE_ERROR, 1'b0, 1'b1, ERR_PORT_CHAR, 17'd0, 1'b0}},
        // the rejected scheme, caught on its colon
        '{"h", 1'b0, 1'b0, NO_TAG},
        '{"t", 1'b0, 1'b0, NO_TAG},
        '{"t", 1'b0, 1'b0, NO_TAG},
        '{"p", 1'b0, 1'b0, NO_TAG},
        '{"s", 1'b0, 1'b0, NO_TAG},
        '{CHAR_COLON, 1'b1, 1'b1, '{ROLE_ERROR, 1'b0, 1'b1, ERR_HTTPS, 17'd0, 1'b0}},
        // clean url with a high byte as host, reports the port out of reset
        '{CHAR_COLON, 1'b0, 1'b0, NO_TAG},
        '{CHAR_SLASH, 1'b0, 1'b0, NO_TAG},
        '{CHAR_SLASH, 1'b0, 1'b0, NO_TAG},
        '{8'h80, 1'b1, 1'b1, '{ROLE_HOST, 1'b1, 1'b1, ERR_NONE, 17'd80, 1'b0}}
    };

    localparam logic [7:0] BANNED_SCHEME [5] = '{"h", "t", "t", "p", "s"};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // side band held with the payload: a typed-in result for this item
    logic        tag_typed = 1'b0;
    out_item_t   tag_want = '0;

    // shared between the sender, the receiver and the watcher
    bit          no_idle = 1'b0;
    bit          hold_off_req = 1'b0;
    int          bad_count = 0;
    int          cycle_count = 0;
    out_item_t   char_tags_due [$];
    logic [7:0]  url_text [$];

    // shadow parse state
    logic [2:0]  url_mode;
    logic [2:0]  scheme_pos;
    logic        scheme_off;
    logic [2:0]  seg_count;
    logic [16:0] port_sum;
    logic        port_taken;
    logic [2:0]  first_error;
    logic        path_taken;
    logic [15:0] port_fallback;

    url_authority_parser #(
        .MAX_PORT_DIGITS(PORT_DIGITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // fresh url: everything but the default port goes back to reset
    function automatic void clear_url();
        url_mode    = MODE_SCHEME;
        scheme_pos  = '0;
        scheme_off  = 1'b0;
        seg_count   = '0;
        port_sum    = '0;
        port_taken  = 1'b0;
        first_error = ERR_NONE;
        path_taken  = 1'b0;
    endfunction

    function automatic void bump_seg();
        if (seg_count < SEG_MAX)
            seg_count++;
    endfunction

    // expected tag and status for one character, advances the shadow state
    function automatic out_item_t parse_char(input in_item_t it);
        out_item_t  res;
        logic [7:0] c;
        logic       is_digit;
        c = it.character;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        res = '0;
        res.char_role = ROLE_ERROR;
        res.done_res = it.last_char;

        // sticky error: every later byte is tagged as after-error
        if (first_error == ERR_NONE)
        begin
            case (url_mode)
                MODE_SCHEME:
                begin
                    if (c == CHAR_COLON)
                    begin
                        if (!scheme_off && scheme_pos == SCHEME_LEN)
                            first_error = ERR_HTTPS;
                        else
                        begin
                            res.char_role = ROLE_SEPARATOR;
                            url_mode = MODE_SEP1;
                        end
                    end
                    else
                    begin
                        res.char_role = ROLE_SCHEME;
                        // exact, case sensitive match against the rejected scheme
                        if (scheme_pos >= SCHEME_LEN || c != BANNED_SCHEME[scheme_pos])
                            scheme_off = 1'b1;
                        if (scheme_pos < SCHEME_LEN)
                            scheme_pos++;
                    end
                end
                MODE_SEP1, MODE_SEP2:
                begin
                    if (c == CHAR_SLASH)
                    begin
                        res.char_role = ROLE_SEPARATOR;
                        if (url_mode == MODE_SEP1)
                            url_mode = MODE_SEP2;
                        else
                        begin
                            url_mode = MODE_HOST;
                            seg_count = '0;
                        end
                    end
                    else
                        first_error = ERR_SEPARATOR;
                end
                MODE_HOST:
                begin
                    if (c == CHAR_COLON || c == CHAR_SLASH)
                    begin
                        if (seg_count == 0)
                            first_error = ERR_EMPTY_HOST;
                        else if (c == CHAR_COLON)
                        begin
                            // the colon and port digits stay in the host copy
                            res.char_role = ROLE_SEPARATOR;
                            res.host_copy = 1'b1;
                            url_mode = MODE_PORT;
                            seg_count = '0;
                            port_sum = '0;
                        end
                        else
                        begin
                            res.char_role = ROLE_PATH;
                            path_taken = 1'b1;
                            url_mode = MODE_PATH;
                        end
                    end
                    else
                    begin
                        res.char_role = ROLE_HOST;
                        res.host_copy = 1'b1;
                        bump_seg();
                    end
                end
                MODE_PORT:
                begin
                    if (c == CHAR_SLASH)
                    begin
                        if (seg_count > PORT_DIGITS)
                            first_error = ERR_PORT_LONG;
                        else if (seg_count == 0)
                            first_error = ERR_PORT_EMPTY;
                        else
                        begin
                            res.char_role = ROLE_PATH;
                            port_taken = 1'b1;
                            path_taken = 1'b1;
                            url_mode = MODE_PATH;
                        end
                    end
                    else if (is_digit)
                    begin
                        res.char_role = ROLE_PORT;
                        res.host_copy = 1'b1;
                        // only the leading digits count toward the value
                        if (seg_count < PORT_DIGITS)
                            port_sum = 17'(port_sum * 10 + (c - CHAR_ZERO));
                        bump_seg();
                    end
                    else
                        first_error = ERR_PORT_CHAR;
                end
                default:
                    res.char_role = ROLE_PATH;
            endcase
        end

        if (!it.last_char)
        begin
            res.status = first_error;
            return res;
        end

        // end of url: unfinished parts turn into errors, the byte keeps its role
        if (first_error == ERR_NONE)
        begin
            case (url_mode)
                MODE_SCHEME:
                    first_error = ERR_NO_COLON;
                MODE_SEP1, MODE_SEP2:
                    first_error = ERR_SEPARATOR;
                MODE_HOST:
                    if (seg_count == 0)
                        first_error = ERR_EMPTY_HOST;
                MODE_PORT:
                begin
                    if (seg_count == 0)
                        first_error = ERR_PORT_EMPTY;
                    else if (seg_count > PORT_DIGITS)
                        first_error = ERR_PORT_LONG;
                    else
                        port_taken = 1'b1;
                end
                default: ;
            endcase
        end

        res.status = first_error;
        if (first_error == ERR_NONE)
        begin
            res.port_value = port_taken ? port_sum : {1'b0, port_fallback};
            res.path_given = path_taken;
        end
        clear_url();
        return res;
    endfunction

    task automatic check_field(input string name, input logic [16:0] want_v,
                               input logic [16:0] seen_v);
        if (seen_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, seen_v);
            bad_count++;
        end
    endtask

    // watcher: predicts on accepted characters, checks accepted results
    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            clear_url();
            port_fallback = DEFAULT_PORT;
        end
        else
        begin
            if (cfg_wr_en)
                port_fallback = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                want = parse_char(in_item);
                char_tags_due.push_back(tag_typed ? tag_want : want);
            end
            if (out_valid && !out_stall)
            begin
                if (char_tags_due.size() == 0)
                begin
                    $error("result item with no character pending");
                    bad_count++;
                end
                else
                begin
                    want = char_tags_due.pop_front();
                    check_field("char_role", want.char_role, out_item.char_role);
                    check_field("host_copy", want.host_copy, out_item.host_copy);
                    check_field("done_res", want.done_res, out_item.done_res);
                    check_field("status", want.status, out_item.status);
                    check_field("port_value", want.port_value, out_item.port_value);
                    check_field("path_given", want.path_given, out_item.path_given);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stall before each item, now and then a long hold-off
    initial
    begin : result_sink
        int wait_n;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                wait_n = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            else
                wait_n = no_idle ? 0 : $urandom_range(7);
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // offer one character and wait for it to be taken; valid stays up
    // across back-to-back items so it never drops and rises in one step
    task automatic offer_char(input logic [7:0] ch, input logic fin, input logic typed,
                              input out_item_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= in_item_t'({ch, fin});
        tag_typed <= typed;
        tag_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait until every pending result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (char_tags_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_default_port(input logic [15:0] port);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= port;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // ordinary byte: never a colon or slash, mostly lower-case letters
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        if ($urandom_range(3) != 0)
            return 8'("a" + $urandom_range(25));
        do
            b = 8'($urandom_range(1, 255));
        while (b == CHAR_COLON || b == CHAR_SLASH);
        return b;
    endfunction

    // noise byte biased toward the characters the parser reacts to
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0: return 8'($urandom_range(1, 255));
            1: return CHAR_COLON;
            2: return CHAR_SLASH;
            default: return 8'(CHAR_ZERO + $urandom_range(9));
        endcase
    endfunction

    // mostly well-formed urls with random content, some damaged, some pure noise
    function automatic void build_url();
        string scheme;
        int    digits;
        int    pos;
        bit    nines;
        url_text.delete();
        case ($urandom_range(6))
            0: scheme = "https";
            1: scheme = "http";
            2: scheme = "httpsx";
            3: scheme = "httPs";
            default: scheme = "";
        endcase
        foreach (scheme[k])
            url_text.push_back(scheme[k]);
        if (scheme.len() == 0 && $urandom_range(2) != 0)
            repeat ($urandom_range(1, 6)) url_text.push_back(plain_byte());
        url_text.push_back(CHAR_COLON);
        url_text.push_back(CHAR_SLASH);
        url_text.push_back(CHAR_SLASH);

        // host, rarely empty
        if ($urandom_range(11) != 0)
            repeat ($urandom_range(1, 8)) url_text.push_back(plain_byte());

        // optional port: mostly a legal length, sometimes empty or too long
        if ($urandom_range(1) == 0)
        begin
            url_text.push_back(CHAR_COLON);
            case ($urandom_range(9))
                7: digits = 0;
                8: digits = 6;
                9: digits = 7;
                default: digits = $urandom_range(1, PORT_DIGITS);
            endcase
            nines = ($urandom_range(4) == 0);
            repeat (digits)
                url_text.push_back(nines ? CHAR_NINE : 8'(CHAR_ZERO + $urandom_range(9)));
        end

        // optional path with any bytes at all
        if ($urandom_range(1) == 0)
        begin
            url_text.push_back(CHAR_SLASH);
            repeat ($urandom_range(6)) url_text.push_back(8'($urandom_range(1, 255)));
        end

        case ($urandom_range(9))
            0:
            begin
                pos = $urandom_range(url_text.size() - 1);
                url_text[pos] = noise_byte();
            end
            1:
            begin
                pos = $urandom_range(1, url_text.size());
                while (url_text.size() > pos)
                    void'(url_text.pop_back());
            end
            2:
            begin
                url_text.delete();
                repeat ($urandom_range(1, 8)) url_text.push_back(noise_byte());
            end
            default: ;
        endcase
    endfunction

    // main sequence
    initial
    begin : stimulus
        int random_sent;
        int cfg_step;
        int holds_left;
        int next_hold;
        logic [15:0] port;
        random_sent = 0;
        cfg_step = 0;
        holds_left = 2;
        next_hold = 300;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, default port still at its reset value
        foreach (DIRECTED[r])
            offer_char(DIRECTED[r].ch, DIRECTED[r].fin, DIRECTED[r].typed, DIRECTED[r].want);

        while (random_sent < RANDOM_ITEMS)
        begin
            // new default port between urls: the extremes first, then random ones
            if (cfg_step < 6 && random_sent >= cfg_step * CFG_SPACING)
            begin
                case (cfg_step)
                    0: port = 16'h0000;
                    1: port = 16'hFFFF;
                    default: port = 16'($urandom);
                endcase
                set_default_port(port);
                cfg_step++;
            end
            // receiver holds off while characters keep coming, so the block backs up
            if (holds_left != 0 && random_sent >= next_hold)
            begin
                hold_off_req = 1'b1;
                holds_left--;
                next_hold += 350;
            end
            if ($urandom_range(7) == 0)
                no_idle = !no_idle;

            build_url();
            foreach (url_text[k])
                offer_char(url_text[k], k == url_text.size() - 1, 1'b0, NO_TAG);
            random_sent += url_text.size();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_count == 0 && char_tags_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
